@@ rtl/idq_pkg.sv @@
// Package for the indexed deque array: sizes, operation and status codes,
// payload structs and the control word broadcast to the entry cells.
// No dependencies.
package idq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned DATA_W   = 32;

  localparam logic [3:0] MODE_PUSH_BACK  = 4'd0;
  localparam logic [3:0] MODE_PUSH_FRONT = 4'd1;
  localparam logic [3:0] MODE_POP_BACK   = 4'd2;
  localparam logic [3:0] MODE_POP_FRONT  = 4'd3;
  localparam logic [3:0] MODE_READ_BACK  = 4'd4;
  localparam logic [3:0] MODE_READ_FRONT = 4'd5;
  localparam logic [3:0] MODE_READ_AT    = 4'd6;
  localparam logic [3:0] MODE_WRITE_AT   = 4'd7;
  localparam logic [3:0] MODE_INSERT_AT  = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic signed [DATA_W-1:0] ERR_VALUE = -32'sd1;

  typedef struct packed {
    logic [3:0]               mode;
    logic [4:0]               position;
    logic signed [DATA_W-1:0] write_value;
  } idq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;
    logic                     empty_res;
  } idq_out_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_INSERT,
    CELL_SHIFT_DOWN
  } cell_op_e;

  typedef struct packed {
    cell_op_e                 op;
    logic [CNT_W-1:0]         sel;
    logic signed [DATA_W-1:0] wdata;
  } cell_ctl_t;

endpackage

@@ rtl/indexed_deque_array.sv @@
// Top level of the indexed deque array: a row of entry cells, the operation
// decoder, the entry count and the result register.
// Depends on idq_pkg, idq_cell and idq_ctrl.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   in_data_i   (idq_in_t)
//   out      output     out_valid_o/out_ready_i out_data_o  (idq_out_t)
//
// Each operation completes at its accepting edge: the row of cells shifts,
// loads or holds all entries in parallel, and the result lands in the
// output register at that same edge.
// Reset clears the entry count and the output valid; cell contents stay
// undefined until written. A stalled result holds the output register and
// blocks new transactions; taking it frees the input in the same cycle.
module indexed_deque_array (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  idq_pkg::idq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output idq_pkg::idq_out_t out_data_o
);
  import idq_pkg::*;

  logic [CNT_W-1:0]                   count_d, count_q;
  logic [CAPACITY-1:0][DATA_W-1:0]    entries;
  cell_ctl_t                          ctl_dec, ctl_cells;
  idq_out_t                           res, out_q;
  logic                               out_valid_q;
  logic                               accept;

  // Take a new transaction when the result register is free or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  idq_ctrl u_ctrl (
    .req_i     (in_data_i),
    .count_i   (count_q),
    .entries_i (entries),
    .ctl_o     (ctl_dec),
    .count_d_o (count_d),
    .res_o     (res)
  );

  // Hold every cell unless a transaction is accepted this cycle.
  always_comb begin
    ctl_cells = ctl_dec;
    if (!accept) ctl_cells.op = CELL_HOLD;
  end

  // Row of cells; each cell sees its lower and upper neighbor.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_lo
      assign left = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_hi
      assign right = entries[g+1];
    end
    idq_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .ctl_i   (ctl_cells),
      .left_i  (left),
      .right_i (right),
      .entry_o (entries[g])
    );
  end

  // Load the next count on every accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // Result register: load on accept, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/idq_cell.sv @@
// One entry cell of the indexed deque array. Holds a single word and takes
// its next value from the broadcast control word or from a neighbor.
// Depends on idq_pkg.
module idq_cell (
  input  logic                              clk_i,
  input  logic [idq_pkg::IDX_W-1:0]         idx_i,
  input  idq_pkg::cell_ctl_t                ctl_i,
  input  logic signed [idq_pkg::DATA_W-1:0] left_i,
  input  logic signed [idq_pkg::DATA_W-1:0] right_i,
  output logic signed [idq_pkg::DATA_W-1:0] entry_o
);
  import idq_pkg::*;

  logic signed [DATA_W-1:0] entry_d, entry_q;
  logic [CNT_W-1:0]         idx_ext;

  assign idx_ext = CNT_W'(idx_i);

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.op)
      CELL_LOAD: begin
        if (idx_ext == ctl_i.sel) entry_d = ctl_i.wdata;
      end
      CELL_INSERT: begin
        if (idx_ext == ctl_i.sel) entry_d = ctl_i.wdata;
        else if (idx_ext > ctl_i.sel) entry_d = left_i;
      end
      CELL_SHIFT_DOWN: entry_d = right_i;
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ rtl/idq_ctrl.sv @@
// Operation decoder of the indexed deque array: checks the request against
// the entry count, picks the cell action and forms the result word.
// Depends on idq_pkg.
module idq_ctrl (
  input  idq_pkg::idq_in_t                                 req_i,
  input  logic [idq_pkg::CNT_W-1:0]                        count_i,
  input  logic [idq_pkg::CAPACITY-1:0][idq_pkg::DATA_W-1:0] entries_i,
  output idq_pkg::cell_ctl_t                               ctl_o,
  output logic [idq_pkg::CNT_W-1:0]                        count_d_o,
  output idq_pkg::idq_out_t                                res_o
);
  import idq_pkg::*;

  logic             full, empty;
  logic [1:0]       status;
  logic             do_read;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] cnt_inc, cnt_dec, pos;

  assign full    = (count_i >= CNT_W'(CAPACITY));
  assign empty   = (count_i == '0);
  assign cnt_inc = count_i + CNT_W'(1);
  assign cnt_dec = count_i - CNT_W'(1);
  assign pos     = req_i.position;

  always_comb begin
    status      = ST_OK;
    do_read     = 1'b0;
    rd_idx      = '0;
    count_d_o   = count_i;
    ctl_o.op    = CELL_HOLD;
    ctl_o.sel   = '0;
    ctl_o.wdata = req_i.write_value;
    case (req_i.mode)
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          count_d_o = cnt_inc;
          if (req_i.mode == MODE_PUSH_BACK) begin
            ctl_o.op  = CELL_LOAD;
            ctl_o.sel = count_i;
          end else begin
            ctl_o.op  = CELL_INSERT;
            ctl_o.sel = '0;
          end
        end
      end
      MODE_POP_BACK, MODE_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_d_o = cnt_dec;
          if (req_i.mode == MODE_POP_FRONT) ctl_o.op = CELL_SHIFT_DOWN;
        end
      end
      MODE_READ_BACK, MODE_READ_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_read = 1'b1;
          rd_idx  = (req_i.mode == MODE_READ_BACK) ? cnt_dec[IDX_W-1:0] : '0;
        end
      end
      MODE_READ_AT, MODE_WRITE_AT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (pos >= count_i) begin
          status = ST_RANGE;
        end else if (req_i.mode == MODE_READ_AT) begin
          do_read = 1'b1;
          rd_idx  = pos[IDX_W-1:0];
        end else begin
          ctl_o.op  = CELL_LOAD;
          ctl_o.sel = pos;
        end
      end
      MODE_INSERT_AT: begin
        if (empty && pos != '0) begin
          status = ST_EMPTY;
        end else if (pos > count_i) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          count_d_o = cnt_inc;
          ctl_o.op  = CELL_INSERT;
          ctl_o.sel = pos;
        end
      end
      default: status = ST_OK;
    endcase
  end

  always_comb begin
    if (status != ST_OK) res_o.read_value = ERR_VALUE;
    else if (do_read)    res_o.read_value = entries_i[rd_idx];
    else                 res_o.read_value = '0;
    res_o.status    = status;
    res_o.count     = count_d_o;
    res_o.empty_res = (count_d_o == '0);
  end

endmodule

@@ rtl/idq_checker.sv @@
// Port-level checks for the indexed deque array, bound to the top level.
// Depends on idq_pkg and indexed_deque_array.
module idq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input idq_pkg::idq_out_t out_data_o
);
  import idq_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Every accepted transaction shows a result in the next cycle.
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after accepted transaction");

  // The empty flag tracks the reported count.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.empty_res == (out_data_o.count == '0))
    else $error("empty flag disagrees with count");

  // Count never exceeds capacity.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // Any failing status carries the error value.
  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.read_value == ERR_VALUE)
    else $error("error status without error value");

endmodule

bind indexed_deque_array idq_checker u_idq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ tb/tb_indexed_deque_array.sv @@
// Self-checking testbench for indexed_deque_array: a directed table, then random
// fill, drain and mixed bursts, checked against typed rows or a cycle-free deque predictor.
// Depends on idq_pkg and the indexed_deque_array RTL.
module tb_indexed_deque_array;
  import idq_pkg::*;

  // Mode codes outside the decoded set; the block must treat them as no-ops.
  localparam logic [3:0] MODE_UNUSED_LO = 4'd9;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEMS_TOTAL  = 950;
  localparam int HOLD_CYCLES  = 60;
  localparam int GAP_CAP      = 300;
  localparam int TAIL_CYCLES  = 4;

  // Burst flavors for the random part.
  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_e;

  // One row of the directed table; want is used only where typed is set.
  typedef struct {
    idq_in_t  op;
    bit       typed;
    idq_out_t want;
  } dir_row_t;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  idq_in_t  in_data   = '0;
  logic     out_ready = 1'b0;
  logic     in_ready;
  logic     out_valid;
  idq_out_t out_data;

  // Shadow copy of the deque, advanced once per accepted transaction.
  logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
  int unsigned              shadow_count;

  // Results still owed by the block, oldest first.
  idq_out_t pending_results [$];
  dir_row_t dir_table [$];

  int fail_cnt  = 0;
  int cycle_cnt = 0;
  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;

  indexed_deque_array uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Kill the run if it hangs; a correct run ends far below this.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Apply one operation to the shadow deque and return the result it owes.
  function automatic idq_out_t deque_apply(idq_in_t op);
    idq_out_t    res;
    int unsigned pos;
    int          i;
    res.read_value = '0;
    res.status     = ST_OK;
    pos            = op.position;
    case (op.mode)
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (op.mode == MODE_PUSH_BACK) begin
          shadow_entries[shadow_count] = op.write_value;
          shadow_count++;
        end else begin
          for (i = shadow_count; i > 0; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[0] = op.write_value;
          shadow_count++;
        end
      end
      MODE_POP_BACK, MODE_POP_FRONT: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (op.mode == MODE_POP_FRONT) begin
            for (i = 0; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          end
          shadow_count--;
        end
      end
      MODE_READ_BACK, MODE_READ_FRONT: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
        else if (op.mode == MODE_READ_BACK) res.read_value = shadow_entries[shadow_count-1];
        else res.read_value = shadow_entries[0];
      end
      MODE_READ_AT, MODE_WRITE_AT: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
        else if (pos >= shadow_count) res.status = ST_RANGE;
        else if (op.mode == MODE_READ_AT) res.read_value = shadow_entries[pos];
        else shadow_entries[pos] = op.write_value;
      end
      MODE_INSERT_AT: begin
        // Empty-with-offset wins over range, and range wins over full.
        if (shadow_count == 0 && pos != 0) begin
          res.status = ST_EMPTY;
        end else if (pos > shadow_count) begin
          res.status = ST_RANGE;
        end else if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[pos] = op.write_value;
          shadow_count++;
        end
      end
      default: ;
    endcase
    if (res.status != ST_OK) res.read_value = ERR_VALUE;
    res.count     = shadow_count[CNT_W-1:0];
    res.empty_res = (shadow_count == 0);
    return res;
  endfunction

  // Build a typed-in result; the empty flag follows from the count.
  function automatic idq_out_t typed_result(logic signed [DATA_W-1:0] v, logic [1:0] s,
                                            logic [CNT_W-1:0] c);
    idq_out_t r;
    r.read_value = v;
    r.status     = s;
    r.count      = c;
    r.empty_res  = (c == 0);
    return r;
  endfunction

  function automatic void add_row(logic [3:0] m, logic [4:0] p, logic signed [DATA_W-1:0] v,
                                  bit typed, idq_out_t want);
    dir_row_t row;
    row.op.mode        = m;
    row.op.position    = p;
    row.op.write_value = v;
    row.typed          = typed;
    row.want           = want;
    dir_table.push_back(row);
  endfunction

  // Draw a random operation shaped by the burst flavor and the current fill level.
  function automatic idq_in_t random_op(burst_e kind);
    idq_in_t op;
    int      r;
    r = $urandom_range(99);
    case (kind)
      BURST_FILL: begin
        if (r < 40)      op.mode = MODE_PUSH_BACK;
        else if (r < 60) op.mode = MODE_PUSH_FRONT;
        else if (r < 85) op.mode = MODE_INSERT_AT;
        else if (r < 95) op.mode = 4'($urandom_range(MODE_READ_BACK, MODE_WRITE_AT));
        else             op.mode = 4'($urandom_range(0, 15));
      end
      BURST_DRAIN: begin
        if (r < 35)      op.mode = MODE_POP_BACK;
        else if (r < 65) op.mode = MODE_POP_FRONT;
        else if (r < 90) op.mode = 4'($urandom_range(MODE_READ_BACK, MODE_WRITE_AT));
        else             op.mode = 4'($urandom_range(0, 15));
      end
      default: begin
        if (r < 90) op.mode = 4'($urandom_range(MODE_PUSH_BACK, MODE_INSERT_AT));
        else        op.mode = 4'($urandom_range(0, 15));
      end
    endcase
    // Keep most positions in or just past the live range, the rest anywhere.
    if ($urandom_range(99) < 80) op.position = 5'($urandom_range(0, shadow_count));
    else                         op.position = 5'($urandom_range(0, 31));
    case ($urandom_range(19))
      0:       op.write_value = 32'sh7FFF_FFFF;
      1:       op.write_value = 32'sh8000_0000;
      2:       op.write_value = '0;
      3:       op.write_value = -32'sd1;
      default: op.write_value = $urandom;
    endcase
    return op;
  endfunction

  // Offer one transaction after a random gap, hold it until taken, then log
  // what the block owes for it.
  task automatic send_op(idq_in_t op, bit typed, idq_out_t want);
    int       gap;
    idq_out_t predicted;
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk_i); while (!in_ready);
    predicted = deque_apply(op);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid and wait for every owed result; never return without advancing the clock.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: stall at random, or hold off a whole stretch when asked.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each taken result with the oldest one owed.
  always @(posedge clk_i) begin
    idq_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: read_value %0d status %0d count %0d",
               out_data.read_value, out_data.status, out_data.count);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_data.read_value);
          fail_cnt++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_cnt++;
        end
        if (out_data.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_data.count);
          fail_cnt++;
        end
        if (out_data.empty_res !== want.empty_res) begin
          $error("empty_res: expected %0d, got %0d", want.empty_res, out_data.empty_res);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    int       phase;
    int       sent;
    int       per_phase;
    int       burst_len;
    burst_e   kind;
    idq_out_t none;

    none         = '0;
    shadow_count = 0;
    foreach (shadow_entries[k]) shadow_entries[k] = '0;

    // Directed table: every empty-array error first, then build a short
    // deque from the value extremes and walk range errors and shifts.
    add_row(MODE_POP_BACK,   5'd0,  '0, 1, typed_result(ERR_VALUE, ST_EMPTY, 5'd0));
    add_row(MODE_POP_FRONT,  5'd0,  '0, 1, typed_result(ERR_VALUE, ST_EMPTY, 5'd0));
    add_row(MODE_READ_BACK,  5'd0,  '0, 1, typed_result(ERR_VALUE, ST_EMPTY, 5'd0));
    add_row(MODE_READ_FRONT, 5'd0,  '0, 1, typed_result(ERR_VALUE, ST_EMPTY, 5'd0));
    add_row(MODE_READ_AT,    5'd0,  '0, 1, typed_result(ERR_VALUE, ST_EMPTY, 5'd0));
    add_row(MODE_WRITE_AT,   5'd0,  32'sd7, 1, typed_result(ERR_VALUE, ST_EMPTY, 5'd0));
    add_row(MODE_INSERT_AT,  5'd5,  32'sd7, 1, typed_result(ERR_VALUE, ST_EMPTY, 5'd0));
    add_row(MODE_INSERT_AT,  5'd0,  32'sh7FFF_FFFF, 1, typed_result('0, ST_OK, 5'd1));
    add_row(MODE_PUSH_BACK,  5'd0,  32'sh8000_0000, 1, typed_result('0, ST_OK, 5'd2));
    add_row(MODE_PUSH_FRONT, 5'd31, -32'sd1, 1, typed_result('0, ST_OK, 5'd3));
    add_row(MODE_READ_FRONT, 5'd0,  '0, 0, none);
    add_row(MODE_READ_BACK,  5'd0,  '0, 0, none);
    add_row(MODE_READ_AT,    5'd1,  '0, 0, none);
    add_row(MODE_READ_AT,    5'd3,  '0, 1, typed_result(ERR_VALUE, ST_RANGE, 5'd3));
    add_row(MODE_WRITE_AT,   5'd31, 32'sd1, 1, typed_result(ERR_VALUE, ST_RANGE, 5'd3));
    add_row(MODE_INSERT_AT,  5'd4,  32'sd1, 1, typed_result(ERR_VALUE, ST_RANGE, 5'd3));
    add_row(MODE_INSERT_AT,  5'd3,  32'sh5A5A_5A5A, 0, none);
    add_row(MODE_WRITE_AT,   5'd2,  '0, 0, none);
    add_row(MODE_INSERT_AT,  5'd1,  32'sh1234_5678, 0, none);
    add_row(MODE_READ_AT,    5'd4,  '0, 0, none);
    add_row(MODE_POP_FRONT,  5'd0,  '0, 0, none);
    add_row(MODE_POP_BACK,   5'd0,  '0, 0, none);
    add_row(MODE_UNUSED_LO,  5'd0,  '0, 0, none);
    add_row(MODE_UNUSED_HI,  5'd31, -32'sd1, 0, none);

    // Hold reset, then release it once.
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[k]) send_op(dir_table[k].op, dir_table[k].typed, dir_table[k].want);
    drain_results();

    // Random part in four idling phases: none, sender idle, receiver stalling,
    // both. Pause the sender between phases until every result is back.
    per_phase = ITEMS_TOTAL / 4;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 88; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      // Back-pressure: hold the receiver off while items keep coming.
      if (phase == 0 || phase == 3) hold_req = 1'b1;
      sent = 0;
      while (sent < per_phase) begin
        // Pick fill, drain or mixed bursts at random so both ends get hit often.
        case ($urandom_range(2))
          0:       kind = BURST_FILL;
          1:       kind = BURST_DRAIN;
          default: kind = BURST_MIXED;
        endcase
        burst_len = $urandom_range(4, 24);
        repeat (burst_len) begin
          send_op(random_op(kind), 0, none);
          sent++;
        end
      end
      drain_results();
    end

    // Let any late activity settle before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/idq_pkg.sv
rtl/idq_cell.sv
rtl/idq_ctrl.sv
rtl/indexed_deque_array.sv
rtl/idq_checker.sv
tb/tb_indexed_deque_array.sv
